// ----- sv/ppm_frame_generator_macros.svh -----
// Assertion helpers used by the verification checker of the frame generator.
`ifndef PPM_FRAME_GENERATOR_MACROS_SVH
`define PPM_FRAME_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PPMFG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppm_frame_generator: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PPMFG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppm_frame_generator: check failed");

`endif

// ----- sv/ppmfg_pkg.sv -----
package ppmfg_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_LENGTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH   = 2'd3;

  // Input kinds carried on in_tuser
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [16:0] RESET_INTERVAL = 17'd100;
  localparam logic [20:0] ELAPSED_MAX    = 21'h1FFFFF;

  typedef struct packed {
    logic [4:0] current_channel;
    logic       frame_started;
    logic       pulse_started;
    logic       line_level;
  } result_t;

endpackage

// ----- sv/ppmfg_skid.sv -----
module ppmfg_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s_valid,
  output logic               s_ready,
  input  ppmfg_pkg::result_t s_data,
  output logic               m_valid,
  input  logic               m_ready,
  output ppmfg_pkg::result_t m_data
);
  import ppmfg_pkg::*;

  logic    main_valid_r;
  logic    skid_valid_r;
  result_t main_data_r;
  result_t skid_data_r;
  logic    main_free;

  assign s_ready   = !skid_valid_r;
  assign m_valid   = main_valid_r;
  assign m_data    = main_data_r;
  assign main_free = !main_valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      // drain the skid entry first so order holds
      main_valid_r <= skid_valid_r || (s_valid && s_ready);
      skid_valid_r <= 1'b0;
    end else if (s_valid && s_ready) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data_r <= skid_valid_r ? skid_data_r : s_data;
    end else if (s_valid && s_ready) begin
      skid_data_r <= s_data;
    end
  end

endmodule

// ----- sv/ppm_frame_generator.sv -----
// PPM frame generator. Every input transaction (a half-microsecond tick or a
// channel table write) produces exactly one result transaction, which goes
// into the result register, or into the skid entry while the output stalls.
// One transaction is taken per clock cycle while in_tready is high; the result
// register plus a one-entry skid stage let the input take one more transaction
// during an output stall, and the input drops ready only while both hold a
// result. Configuration writes take effect at the next marker or gap event.
// After reset the line stays inactive for 100 ticks before the first marker.
module ppm_frame_generator #(
  parameter int MAX_CHANNELS       = 16,
  parameter int DEFAULT_CHANNEL_US = 1500
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [3:0] channel_index, [19:4] channel_value_us, [23:20] zero
  input  logic [ppmfg_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] func
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] line_level, [1] pulse_started, [2] frame_started, [7:3] current_channel
  output logic [ppmfg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [ppmfg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ppmfg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ppmfg_pkg::*;

  localparam int PW = $clog2(MAX_CHANNELS + 1);
  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [5:0]  MAX_CNT   = 6'(MAX_CHANNELS);
  localparam logic [15:0] DEF_SPACE = 16'(DEFAULT_CHANNEL_US);

  // configuration
  logic [4:0]  channel_count_r;
  logic [15:0] pulse_len_r;
  logic [15:0] frame_len_r;
  logic        active_high_r;

  // frame state
  logic          pending_r, pending_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [20:0]   elapsed_r, elapsed_nxt;
  logic [16:0]   interval_r, interval_nxt;
  logic [16:0]   tick_r, tick_nxt;
  logic          line_r, line_nxt;
  logic [15:0]   tbl_r [MAX_CHANNELS];

  logic           in_acc;
  logic           skid_ready;
  logic [3:0]     wr_idx;
  logic [15:0]    wr_val;
  logic [IW+3:0]  wr_idx_ext;
  logic           wr_hit;
  logic [15:0]    tbl_rd;
  logic [5:0]     cnt_lim;
  logic [5:0]     pos6;
  logic [16:0]    tick_inc;
  logic           fire;
  logic signed [22:0] frame_gap;
  logic signed [17:0] chan_gap;
  logic [21:0]    elapsed_sum;
  logic [PW+4:0]  pos_ext;
  logic           pulse_flag, frame_flag;
  result_t        res;
  result_t        out_res;

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = skid_ready;
  assign wr_idx     = in_tdata[3:0];
  assign wr_val     = in_tdata[19:4];
  assign wr_idx_ext = {{IW{1'b0}}, wr_idx};
  assign wr_hit     = (in_tuser == FUNC_WRITE) && (wr_idx_ext < (IW+4)'(MAX_CHANNELS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= 5'd8;
      pulse_len_r     <= 16'd300;
      frame_len_r     <= 16'd20000;
      active_high_r   <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[4:0];
        REG_PULSE_LENGTH:  pulse_len_r     <= cfg_wdata;
        REG_FRAME_LENGTH:  frame_len_r     <= cfg_wdata;
        REG_ACTIVE_HIGH:   active_high_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign tbl_rd      = tbl_r[pos_r[IW-1:0]];
  assign cnt_lim     = ({1'b0, channel_count_r} > MAX_CNT) ? MAX_CNT : {1'b0, channel_count_r};
  assign pos6        = 6'(pos_r);
  assign tick_inc    = tick_r + 17'd1;
  assign fire        = (in_tuser == FUNC_TICK) && (tick_inc >= interval_r);
  assign frame_gap   = $signed({7'b0, frame_len_r}) - $signed({2'b0, elapsed_r})
                     - $signed({7'b0, pulse_len_r});
  assign chan_gap    = $signed({2'b0, tbl_rd}) - $signed({2'b0, pulse_len_r});
  assign elapsed_sum = {1'b0, elapsed_r} + {6'b0, tbl_rd};

  always_comb begin
    pending_nxt  = pending_r;
    pos_nxt      = pos_r;
    elapsed_nxt  = elapsed_r;
    interval_nxt = interval_r;
    tick_nxt     = tick_r;
    line_nxt     = line_r;
    pulse_flag   = 1'b0;
    frame_flag   = 1'b0;
    if (in_tuser == FUNC_TICK) begin
      tick_nxt = tick_inc;
      if (fire) begin
        tick_nxt = '0;
        if (pending_r) begin
          // start the marker pulse
          line_nxt     = active_high_r;
          interval_nxt = (pulse_len_r == 16'd0) ? 17'd1 : {pulse_len_r, 1'b0};
          pending_nxt  = 1'b0;
          pulse_flag   = 1'b1;
          frame_flag   = (pos_r == '0);
        end else begin
          line_nxt    = !active_high_r;
          pending_nxt = 1'b1;
          if (pos6 >= cnt_lim) begin
            // sync gap: rest of the frame
            interval_nxt = (frame_gap < 23'sd1) ? 17'd1 : {frame_gap[15:0], 1'b0};
            pos_nxt      = '0;
            elapsed_nxt  = '0;
          end else begin
            interval_nxt = (chan_gap < 18'sd1) ? 17'd1 : {chan_gap[15:0], 1'b0};
            elapsed_nxt  = elapsed_sum[21] ? ELAPSED_MAX : elapsed_sum[20:0];
            pos_nxt      = pos_r + PW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b1;
      pos_r      <= PW'(MAX_CHANNELS);
      elapsed_r  <= '0;
      interval_r <= RESET_INTERVAL;
      tick_r     <= '0;
      line_r     <= 1'b0;
    end else if (in_acc) begin
      pending_r  <= pending_nxt;
      pos_r      <= pos_nxt;
      elapsed_r  <= elapsed_nxt;
      interval_r <= interval_nxt;
      tick_r     <= tick_nxt;
      line_r     <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        tbl_r[i] <= DEF_SPACE;
      end
    end else if (in_acc && wr_hit) begin
      tbl_r[wr_idx_ext[IW-1:0]] <= wr_val;
    end
  end

  assign pos_ext = {5'b0, pos_nxt};

  always_comb begin
    res.line_level      = line_nxt;
    res.pulse_started   = pulse_flag;
    res.frame_started   = frame_flag;
    res.current_channel = pos_ext[4:0];
  end

  ppmfg_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (skid_ready),
    .s_data  (res),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_res)
  );

  assign out_tdata = out_res;

endmodule

// ----- sv/ppmfg_checker.sv -----
`include "ppm_frame_generator_macros.svh"

module ppmfg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ppmfg_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result transaction holds its payload
  `PPMFG_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // a frame starts only with a marker pulse
  `PPMFG_ASSERT_IMP(a_frame_has_pulse, out_tvalid && out_tdata[2], out_tdata[1])
  // a frame starts on channel zero
  `PPMFG_ASSERT_IMP(a_frame_chan0, out_tvalid && out_tdata[2], out_tdata[7:3] == 5'd0)
  // no result right after reset
  `PPMFG_ASSERT_IMP(a_reset_empty, !$past(rst_n), !out_tvalid)

endmodule

bind ppm_frame_generator ppmfg_checker u_ppmfg_checker (.*);
